// File: src/min_stack_per_entry_minimum_assert.svh
// assertion macros used by the checker file
`ifndef MIN_STACK_PER_ENTRY_MINIMUM_ASSERT_SVH
`define MIN_STACK_PER_ENTRY_MINIMUM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MSK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min stack assertion failed");

// next-cycle implication, disabled during reset
`define MSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min stack assertion failed");

`endif

// File: src/min_stk_pkg.sv
// package with word types, codes and defaults of the min stack
package min_stk_pkg;

   localparam int DEF_STACK_DEPTH = 1024;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DATA_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 11;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                         op;
      logic signed [DATA_WIDTH-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] top_value;
      logic signed [DATA_WIDTH-1:0] min_value;
      logic [COUNT_WIDTH-1:0]       entry_count;
      logic                         is_empty;
      logic [1:0]                   status;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic fill;
      logic publish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_fill;
   } ctl_status_type;

endpackage

// File: src/min_stk_ctrl.sv
// controller state machine of the min stack
module min_stk_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  min_stk_pkg::ctl_status_type status,
   output min_stk_pkg::ctl_cmd_type    cmd
);
   import min_stk_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_POST = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.needs_fill ? S_FILL : S_POST;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_POST;
         end
         S_POST: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/min_stk_dpath.sv
// datapath of the min stack: cached top entry, entry memory, result register
module min_stk_dpath #(
   parameter int STACK_DEPTH = min_stk_pkg::DEF_STACK_DEPTH,
   parameter int VALUE_WIDTH = min_stk_pkg::DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  min_stk_pkg::req_word_type   req_word,
   output min_stk_pkg::rsp_word_type   rsp_word,
   input  min_stk_pkg::ctl_cmd_type    cmd,
   output min_stk_pkg::ctl_status_type status
);
   import min_stk_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // entries below the top one
   logic [VALUE_WIDTH-1:0] val_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] min_mem [STACK_DEPTH];

   logic                   op_ff;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] top_val_ff, top_val_in;
   logic [VALUE_WIDTH-1:0] top_min_ff, top_min_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [1:0]             code_ff, code_in;
   logic [VALUE_WIDTH-1:0] rd_val_ff, rd_min_ff;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   mem_we;
   logic [CW-1:0]          count_m1, count_m2;
   logic                   is_full, is_zero;
   logic [DATA_WIDTH-1:0]  out_top, out_min;

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign is_full  = (count_ff == CW'(STACK_DEPTH));
   assign is_zero  = (count_ff == '0);

   assign status.needs_fill = (op_ff == OP_POP) && (count_ff >= CW'(2));

   // sign-extend or truncate the 32-bit input to the stored width
   always_comb begin
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         value_in[i] = req_word.value[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
      end
   end

   // stored width back to the 32-bit field, zero above the stored width
   always_comb begin
      for (int i = 0; i < DATA_WIDTH; i++) begin
         out_top[i] = (i < VALUE_WIDTH) ? top_val_ff[(i < VALUE_WIDTH) ? i : 0] : 1'b0;
         out_min[i] = (i < VALUE_WIDTH) ? top_min_ff[(i < VALUE_WIDTH) ? i : 0] : 1'b0;
      end
   end

   always_comb begin
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      count_in   = count_ff;
      code_in    = code_ff;
      mem_we     = 1'b0;
      if (cmd.execute) begin
         code_in = ST_OK;
         if (op_ff == OP_PUSH) begin
            if (is_full) begin
               code_in = ST_FULL;
            end else begin
               mem_we     = !is_zero;
               top_val_in = value_ff;
               top_min_in = (!is_zero && ($signed(top_min_ff) < $signed(value_ff)))
                            ? top_min_ff : value_ff;
               count_in   = count_ff + CW'(1);
            end
         end else begin
            if (is_zero) begin
               code_in = ST_EMPTY;
            end else begin
               count_in = count_m1;
            end
         end
      end else if (cmd.fill) begin
         top_val_in = rd_val_ff;
         top_min_in = rd_min_ff;
      end
   end

   always_comb begin
      rsp_word_in             = rsp_word_ff;
      rsp_word_in.top_value   = is_zero ? '0 : out_top;
      rsp_word_in.min_value   = is_zero ? '0 : out_min;
      rsp_word_in.entry_count = COUNT_WIDTH'(count_ff);
      rsp_word_in.is_empty    = is_zero;
      rsp_word_in.status      = code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_word.op;
         value_ff <= value_in;
      end
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      code_ff    <= code_in;
      if (cmd.publish) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // old top goes down on push, entry below top is read on pop
   always_ff @(posedge clock) begin
      if (mem_we) begin
         val_mem[count_m1[AW-1:0]] <= top_val_ff;
         min_mem[count_m1[AW-1:0]] <= top_min_ff;
      end
      if (cmd.execute) begin
         rd_val_ff <= val_mem[count_m2[AW-1:0]];
         rd_min_ff <= min_mem[count_m2[AW-1:0]];
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

// File: src/min_stack_per_entry_minimum.sv
// top level of the min stack: controller plus datapath
//
// stack of signed values that also reports the running minimum
// req channel: one word per operation, op push (with value) or pop
// rsp channel: one word per request, giving the state after the operation:
//    top value, minimum, entry count, empty flag and status
// a push on a full stack is dropped with status full, a pop on an empty
//    stack is ignored with status empty; top and minimum read zero when empty
// the top entry lives in registers, the entries below it in a memory
// sequence: an accepted request is captured and executed; a pop that leaves
//    entries then moves the registered memory read into the top registers,
//    while a push, an ignored pop or a pop that empties the stack skips that;
//    the result is published once the result register is free
// one request is worked at a time; req_stall is low only while the controller is idle
// a finished word sits in the result register; a new request is taken
//    while it waits, and the next result waits in the controller until
//    the rsp side stops stalling
// reset clears the entry count and the result valid; memory contents are
//    not cleared, since only written entries are ever read
module min_stack_per_entry_minimum #(
   parameter int STACK_DEPTH = min_stk_pkg::DEF_STACK_DEPTH,
   parameter int VALUE_WIDTH = min_stk_pkg::DEF_VALUE_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  min_stk_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output min_stk_pkg::rsp_word_type rsp_word
);
   import min_stk_pkg::*;

   // command and status between the two halves
   ctl_cmd_type    cmd;
   ctl_status_type status;

   // sequencing: accept, execute, optional memory refill, publish
   min_stk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // top registers, entry memory and result word register
   min_stk_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .rsp_word (rsp_word),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: src/min_stk_checker.sv
// port checker for the min stack, with its bind
`include "min_stack_per_entry_minimum_assert.svh"

module min_stk_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input min_stk_pkg::rsp_word_type rsp_word
);
   import min_stk_pkg::*;

   `MSK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `MSK_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_word.is_empty, (rsp_word.entry_count == '0) && (rsp_word.top_value == '0) && (rsp_word.min_value == '0))
   `MSK_ASSERT_IMPLY(a_min_le_top, clock, reset, rsp_valid && !rsp_word.is_empty && (rsp_word.top_value[DATA_WIDTH-1] == rsp_word.min_value[DATA_WIDTH-1]), rsp_word.min_value <= rsp_word.top_value)
   `MSK_ASSERT_IMPLY(a_full_not_empty, clock, reset, rsp_valid && (rsp_word.status == ST_FULL), !rsp_word.is_empty && (rsp_word.status != ST_EMPTY))

endmodule

bind min_stack_per_entry_minimum min_stk_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// File: sim/min_stack_per_entry_minimum_tb.sv
// testbench of the min stack: random push and pop words against a running stack predictor
`timescale 1ns / 100ps

module min_stack_per_entry_minimum_tb;
   import min_stk_pkg::*;

   localparam int STACK_DEPTH = DEF_STACK_DEPTH;
   localparam int VALUE_WIDTH = DEF_VALUE_WIDTH;
   // cycles with no word moving on either side before the run is given up
   localparam int QUIET_LIMIT = 2000;
   // settle time after the last result
   localparam int TAIL_CYCLES = 20;
   // accepted-word window in which neither side idles
   localparam int CALM_FROM = 700;
   localparam int CALM_TO   = 1000;

   localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh80000000;

   // one pending request word, optionally held back until nothing is outstanding
   typedef struct {
      req_word_type word;
      bit           hold_for_drain;
   } stack_op_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   stack_op_type pending_ops_q[$];
   rsp_word_type expected_state_q[$];

   // predictor state: per-entry value and running minimum, plus depth
   logic signed [DATA_WIDTH-1:0] value_mem [STACK_DEPTH];
   logic signed [DATA_WIDTH-1:0] minimum_mem [STACK_DEPTH];
   int model_depth = 0;

   // depth as seen by the stimulus generator, used to steer the sequences
   int gen_depth = 0;

   int  mismatch_count = 0;
   int  ops_taken      = 0;
   int  quiet_cycles   = 0;
   bit  req_taken      = 1'b0;
   bit  calm;

   min_stack_per_entry_minimum #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   // no idling on either side during one long stretch of the run
   assign calm = (ops_taken >= CALM_FROM) && (ops_taken < CALM_TO);

   // apply one operation to the predictor and return the state word it leaves
   function automatic rsp_word_type apply_stack_op(input req_word_type w);
      rsp_word_type                 r;
      logic signed [DATA_WIDTH-1:0] run_min;
      r        = '0;
      r.status = ST_OK;
      if (w.op == OP_PUSH) begin
         if (model_depth >= STACK_DEPTH) begin
            // full: push dropped, stack untouched
            r.status = ST_FULL;
         end else begin
            run_min = w.value;
            if (model_depth > 0 && minimum_mem[model_depth-1] < w.value) begin
               run_min = minimum_mem[model_depth-1];
            end
            value_mem[model_depth]   = w.value;
            minimum_mem[model_depth] = run_min;
            model_depth++;
         end
      end else begin
         // empty: pop ignored
         if (model_depth == 0) r.status = ST_EMPTY;
         else model_depth--;
      end
      // top and minimum read zero on an empty stack
      if (model_depth > 0) begin
         r.top_value = value_mem[model_depth-1];
         r.min_value = minimum_mem[model_depth-1];
      end
      r.entry_count = model_depth[COUNT_WIDTH-1:0];
      r.is_empty    = (model_depth == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field_name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", field_name, got, want));
      end
   endtask

   // queue one operation and track the depth it leads to
   task automatic queue_op(input logic op, input logic signed [DATA_WIDTH-1:0] value,
                           input bit hold);
      stack_op_type item;
      item.word.op        = op;
      item.word.value     = value;
      item.hold_for_drain = hold;
      pending_ops_q.push_back(item);
      if (op == OP_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
      else if (op == OP_POP && gen_depth > 0) gen_depth--;
   endtask

   // values lean toward the extremes and a narrow band, so ties on the minimum occur
   function automatic logic signed [DATA_WIDTH-1:0] rand_value();
      int pick;
      pick = $urandom_range(15);
      case (pick)
         0: return VAL_MAX;
         1: return VAL_MIN;
         2, 3: return $urandom_range(16) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic rand_op(input int push_pct);
      return ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
   endfunction

   // request driver: a word holds until taken, then the next one or an idle cycle
   always @(negedge clock) begin : drive_req
      stack_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops_q.size() != 0
             && (!pending_ops_q[0].hold_for_drain || expected_state_q.size() == 0)
             && (calm || $urandom_range(99) >= 33)) begin
            nxt = pending_ops_q.pop_front();
            req_word  <= nxt.word;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stalls at random, except inside the calm window
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 33);
   end

   // monitor: results checked before the same-edge request is predicted
   always @(posedge clock) begin : watch_ports
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_state_q.size() == 0) begin
               report_mismatch("rsp word with nothing expected");
            end else begin
               want = expected_state_q.pop_front();
               check_field("top_value", rsp_word.top_value, want.top_value);
               check_field("min_value", rsp_word.min_value, want.min_value);
               check_field("entry_count", rsp_word.entry_count, want.entry_count);
               check_field("is_empty", rsp_word.is_empty, want.is_empty);
               check_field("status", rsp_word.status, want.status);
            end
         end
         if (req_valid && !req_stall) begin
            expected_state_q.push_back(apply_stack_op(req_word));
            ops_taken <= ops_taken + 1;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // watchdog on cycles in which no word moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // directed: pop on empty, extremes, ties on the minimum, bit patterns
      queue_op(OP_POP, 32'sh0, 1'b0);
      queue_op(OP_PUSH, VAL_MAX, 1'b0);
      queue_op(OP_PUSH, VAL_MIN, 1'b0);
      queue_op(OP_PUSH, 32'sh0, 1'b0);
      queue_op(OP_PUSH, VAL_MIN, 1'b0);
      queue_op(OP_PUSH, -32'sd1, 1'b0);
      queue_op(OP_PUSH, 32'sd1, 1'b0);
      repeat (6) queue_op(OP_POP, VAL_MAX, 1'b0);
      queue_op(OP_POP, VAL_MIN, 1'b0);
      queue_op(OP_PUSH, -32'sd5, 1'b0);
      queue_op(OP_PUSH, 32'sd7, 1'b0);
      queue_op(OP_PUSH, -32'sd5, 1'b0);
      queue_op(OP_PUSH, -32'sd6, 1'b0);
      repeat (4) queue_op(OP_POP, 32'sh55555555, 1'b0);
      queue_op(OP_PUSH, 32'sh55555555, 1'b0);
      queue_op(OP_PUSH, 32'shaaaaaaaa, 1'b0);
      repeat (2) queue_op(OP_POP, 32'shaaaaaaaa, 1'b0);

      // shallow random walk, keeps hitting the empty stack; first word waits for a drain
      queue_op(rand_op(50), rand_value(), 1'b1);
      repeat (300) queue_op(rand_op(50), rand_value(), 1'b0);

      // fill up to full, then hammer the full boundary
      while (gen_depth < STACK_DEPTH) queue_op(rand_op(95), rand_value(), 1'b0);
      repeat (24) queue_op(rand_op(70), rand_value(), 1'b0);

      // pop-heavy stretch back down, again starting from a drained pipeline
      queue_op(OP_POP, rand_value(), 1'b1);
      repeat (500) queue_op(rand_op(30), rand_value(), 1'b0);

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_ops_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_state_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
